>>> hw/rtl/column_major_index_converter_defines.svh
// Assertion macros for the index converter.
`ifndef COLUMN_MAJOR_INDEX_CONVERTER_DEFINES_SVH
`define COLUMN_MAJOR_INDEX_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CMIC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cmic check failed");

// Next-cycle implication, checked out of reset.
`define CMIC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cmic check failed");

`endif

>>> hw/rtl/cmic_pkg.sv
package cmic_pkg;

	localparam int DIM_BITS     = 10;
	localparam int MAX_DIMS     = 4;
	localparam int CARRIED_DIMS = 4;
	localparam int FLAT_W       = 40;
	localparam int CNT_W        = 3;
	localparam int IDX_W        = 3;
	localparam int DIM_LIMIT    = (MAX_DIMS < CARRIED_DIMS) ? MAX_DIMS : CARRIED_DIMS;

	// Register indexes on the write port
	localparam logic [IDX_W-1:0] REG_DIM_COUNT = 3'd0;
	localparam logic [IDX_W-1:0] REG_SIZE0     = 3'd1;
	localparam logic [IDX_W-1:0] REG_SIZE1     = 3'd2;
	localparam logic [IDX_W-1:0] REG_SIZE2     = 3'd3;
	localparam logic [IDX_W-1:0] REG_SIZE3     = 3'd4;

	typedef struct packed {
		logic                kind;
		logic [DIM_BITS-1:0] sub_in0;
		logic [DIM_BITS-1:0] sub_in1;
		logic [DIM_BITS-1:0] sub_in2;
		logic [DIM_BITS-1:0] sub_in3;
		logic [FLAT_W-1:0]   flat_in;
	} req_t;

	typedef struct packed {
		logic [FLAT_W-1:0]   flat_out;
		logic [DIM_BITS-1:0] sub_out0;
		logic [DIM_BITS-1:0] sub_out1;
		logic [DIM_BITS-1:0] sub_out2;
		logic [DIM_BITS-1:0] sub_out3;
		logic                out_of_bounds;
	} res_t;

	typedef logic [CARRIED_DIMS-1:0][DIM_BITS-1:0] sub_arr_t;
	typedef logic [CARRIED_DIMS-1:1][FLAT_W-1:0]   stride_t;

	// Data that rides along the split pipeline
	typedef struct packed {
		logic              kind;
		logic              oob;
		logic [FLAT_W-1:0] flat;
	} side_t;

endpackage

>>> hw/rtl/column_major_index_converter.sv
// Channel | Signals                     | Beat taken when
// --------+-----------------------------+----------------------------
// request | start, busy, req            | start && !busy
// result  | done, res                   | done (one cycle, no backpressure)
// config  | cfg_we, cfg_idx, cfg_wdata  | cfg_we
//
// One request per cycle; busy stays low, there is nothing to stall.
// Six stages build strides, the element count and the weighted sum,
// thirty restoring-division stages (one quotient bit each) split the
// flat number, and one output register follows.
// Reset clears pipeline valids and sets the shape to 2 dims of extent 1.
// Config is sampled when a request enters the first stage.
module column_major_index_converter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  cmic_pkg::req_t               req,
	output logic                         done,
	output cmic_pkg::res_t               res,
	input  logic                         cfg_we,
	input  logic [cmic_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [cmic_pkg::DIM_BITS-1:0] cfg_wdata
);
	import cmic_pkg::*;

	localparam int P2_W = 2 * DIM_BITS;
	localparam int P3_W = 3 * DIM_BITS;
	localparam int LAT  = 6 + (CARRIED_DIMS - 1) * DIM_BITS + 1;

	// ---------------- configuration registers ----------------
	logic [CNT_W-1:0]    dim_count_q;
	logic [DIM_BITS-1:0] size_q [CARRIED_DIMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= CNT_W'(2);
			for (int i = 0; i < CARRIED_DIMS; i++) size_q[i] <= DIM_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DIM_COUNT: dim_count_q <= cfg_wdata[CNT_W-1:0];
				REG_SIZE0:     size_q[0]   <= cfg_wdata;
				REG_SIZE1:     size_q[1]   <= cfg_wdata;
				REG_SIZE2:     size_q[2]   <= cfg_wdata;
				REG_SIZE3:     size_q[3]   <= cfg_wdata;
				default:       ;  // indexes past the list are dropped
			endcase
		end
	end

	assign busy = 1'b0;
	wire accept = start && !busy;

	// ---------------- stage 1: clamp, mask, bounds ----------------
	// Unused dims act as extent 1 with index 0, so they drop out of
	// both the sum and the split.
	logic [CNT_W-1:0]    n_d;
	logic [DIM_BITS-1:0] sub_d [CARRIED_DIMS];
	logic [DIM_BITS-1:0] ext_d [CARRIED_DIMS];
	logic [DIM_BITS-1:0] sub_raw [CARRIED_DIMS];
	logic                bad_d;

	assign sub_raw[0] = req.sub_in0;
	assign sub_raw[1] = req.sub_in1;
	assign sub_raw[2] = req.sub_in2;
	assign sub_raw[3] = req.sub_in3;

	always_comb begin
		priority if (dim_count_q == '0) begin
			n_d = CNT_W'(1);
		end else if (dim_count_q > CNT_W'(DIM_LIMIT)) begin
			n_d = CNT_W'(DIM_LIMIT);
		end else begin
			n_d = dim_count_q;
		end
		bad_d = 1'b0;
		for (int i = 0; i < CARRIED_DIMS; i++) begin
			if (CNT_W'(i) < n_d) begin
				ext_d[i] = size_q[i];
				sub_d[i] = sub_raw[i];
			end else begin
				ext_d[i] = DIM_BITS'(1);
				sub_d[i] = '0;
			end
			bad_d = bad_d | (sub_d[i] >= ext_d[i]);
		end
	end

	logic                v_s1, kind_s1, bad_s1;
	logic [FLAT_W-1:0]   flat_s1;
	logic [DIM_BITS-1:0] sub_s1 [CARRIED_DIMS];
	logic [DIM_BITS-1:0] ext_s1 [CARRIED_DIMS];

	// stage 2: product of extents 0..1
	logic                v_s2, kind_s2, bad_s2;
	logic [FLAT_W-1:0]   flat_s2;
	logic [DIM_BITS-1:0] sub_s2 [CARRIED_DIMS];
	logic [DIM_BITS-1:0] ext_s2 [CARRIED_DIMS];
	logic [P2_W-1:0]     p01_s2;

	// stage 3: product 0..2, weight of index 1
	logic                v_s3, kind_s3, bad_s3;
	logic [FLAT_W-1:0]   flat_s3;
	logic [DIM_BITS-1:0] sub0_s3, sub2_s3, sub3_s3, ext0_s3, ext3_s3;
	logic [P2_W-1:0]     p01_s3, t1_s3;
	logic [P3_W-1:0]     p012_s3;

	// stage 4: element count, weight of index 2, partial sum
	logic                v_s4, kind_s4, bad_s4;
	logic [FLAT_W-1:0]   flat_s4, count_s4, acc_s4;
	logic [DIM_BITS-1:0] sub3_s4, ext0_s4;
	logic [P2_W-1:0]     p01_s4;
	logic [P3_W-1:0]     p012_s4, t2_s4;

	// stage 5: weight of index 3, bounds decision
	logic                v_s5, kind_s5, oob_s5;
	logic [FLAT_W-1:0]   flat_s5, acc_s5, t3_s5;
	stride_t             stride_s5;

	// stage 6: final sum, split operand
	logic                v_s6;
	logic [FLAT_W-1:0]   rem_s6;
	stride_t             stride_s6;
	side_t               side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// s1
		kind_s1 <= req.kind;
		bad_s1  <= bad_d;
		flat_s1 <= req.flat_in;
		sub_s1  <= sub_d;
		ext_s1  <= ext_d;
		// s2
		kind_s2 <= kind_s1;
		bad_s2  <= bad_s1;
		flat_s2 <= flat_s1;
		sub_s2  <= sub_s1;
		ext_s2  <= ext_s1;
		p01_s2  <= P2_W'(ext_s1[0]) * P2_W'(ext_s1[1]);
		// s3
		kind_s3 <= kind_s2;
		bad_s3  <= bad_s2;
		flat_s3 <= flat_s2;
		sub0_s3 <= sub_s2[0];
		sub2_s3 <= sub_s2[2];
		sub3_s3 <= sub_s2[3];
		ext0_s3 <= ext_s2[0];
		ext3_s3 <= ext_s2[3];
		p01_s3  <= p01_s2;
		p012_s3 <= P3_W'(p01_s2) * P3_W'(ext_s2[2]);
		t1_s3   <= P2_W'(sub_s2[1]) * P2_W'(ext_s2[0]);
		// s4
		kind_s4  <= kind_s3;
		bad_s4   <= bad_s3;
		flat_s4  <= flat_s3;
		sub3_s4  <= sub3_s3;
		ext0_s4  <= ext0_s3;
		p01_s4   <= p01_s3;
		p012_s4  <= p012_s3;
		count_s4 <= FLAT_W'(p012_s3) * FLAT_W'(ext3_s3);
		t2_s4    <= P3_W'(sub2_s3) * P3_W'(p01_s3);
		acc_s4   <= FLAT_W'(sub0_s3) + FLAT_W'(t1_s3);
		// s5
		kind_s5      <= kind_s4;
		flat_s5      <= flat_s4;
		oob_s5       <= kind_s4 ? (flat_s4 >= count_s4) : bad_s4;
		acc_s5       <= acc_s4 + FLAT_W'(t2_s4);
		t3_s5        <= FLAT_W'(sub3_s4) * FLAT_W'(p012_s4);
		stride_s5[1] <= FLAT_W'(ext0_s4);
		stride_s5[2] <= FLAT_W'(p01_s4);
		stride_s5[3] <= FLAT_W'(p012_s4);
		// s6
		stride_s6     <= stride_s5;
		side_s6.kind  <= kind_s5;
		side_s6.oob   <= oob_s5;
		side_s6.flat  <= (kind_s5 || oob_s5) ? '0 : (acc_s5 + t3_s5);
		rem_s6        <= (kind_s5 && !oob_s5) ? flat_s5 : '0;
	end

	// ---------------- split: flat number to indices ----------------
	logic     split_vld;
	sub_arr_t split_sub;
	side_t    split_side;

	cmic_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (v_s6),
		.rem      (rem_s6),
		.stride   (stride_s6),
		.side     (side_s6),
		.out_vld  (split_vld),
		.sub      (split_sub),
		.out_side (split_side)
	);

	// ---------------- result register ----------------
	logic done_q;
	res_t res_q;
	wire  keep_sub = split_side.kind && !split_side.oob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= split_vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q.flat_out      <= split_side.flat;
		res_q.sub_out0      <= keep_sub ? split_sub[0] : '0;
		res_q.sub_out1      <= keep_sub ? split_sub[1] : '0;
		res_q.sub_out2      <= keep_sub ? split_sub[2] : '0;
		res_q.sub_out3      <= keep_sub ? split_sub[3] : '0;
		res_q.out_of_bounds <= split_side.oob;
	end

	assign done = done_q;
	assign res  = res_q;

`include "column_major_index_converter_defines.svh"

	`CMIC_ASSERT_IMP(a_latency, done, $past(accept, LAT))
	`CMIC_ASSERT_IMP(a_oob_zero, done && res.out_of_bounds,
		res.flat_out == '0 && res.sub_out0 == '0 && res.sub_out1 == '0 && res.sub_out2 == '0 && res.sub_out3 == '0)
	`CMIC_ASSERT_IMP(a_one_mode, done && res.flat_out != '0,
		res.sub_out0 == '0 && res.sub_out1 == '0 && res.sub_out2 == '0 && res.sub_out3 == '0)
	`CMIC_ASSERT_NXT(a_enter, accept, v_s1)

endmodule

>>> hw/rtl/cmic_split.sv
module cmic_split (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  logic [cmic_pkg::FLAT_W-1:0] rem,
	input  cmic_pkg::stride_t stride,
	input  cmic_pkg::side_t   side,
	output logic              out_vld,
	output cmic_pkg::sub_arr_t sub,
	output cmic_pkg::side_t   out_side
);
	import cmic_pkg::*;

	// one quotient bit per stage, highest dimension first
	localparam int NSTEP   = (CARRIED_DIMS - 1) * DIM_BITS;
	localparam int TRIAL_W = FLAT_W + DIM_BITS;

	logic              vld_s    [NSTEP+1];
	logic [FLAT_W-1:0] rem_s    [NSTEP+1];
	stride_t           stride_s [NSTEP+1];
	side_t             side_s   [NSTEP+1];
	sub_arr_t          quo_s    [NSTEP+1];

	assign vld_s[0]    = vld;
	assign rem_s[0]    = rem;
	assign stride_s[0] = stride;
	assign side_s[0]   = side;
	assign quo_s[0]    = '0;

	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		localparam int DIM = CARRIED_DIMS - 1 - j / DIM_BITS;
		localparam int BIT = DIM_BITS - 1 - j % DIM_BITS;

		logic [TRIAL_W-1:0] trial;
		logic               take;
		logic [FLAT_W-1:0]  rem_nx;
		sub_arr_t           quo_nx;

		always_comb begin
			trial  = TRIAL_W'(stride_s[j][DIM]) << BIT;
			take   = TRIAL_W'(rem_s[j]) >= trial;
			rem_nx = take ? (rem_s[j] - trial[FLAT_W-1:0]) : rem_s[j];
			quo_nx = quo_s[j];
			quo_nx[DIM][BIT] = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1]    <= rem_nx;
			stride_s[j+1] <= stride_s[j];
			side_s[j+1]   <= side_s[j];
			quo_s[j+1]    <= quo_nx;
		end
	end

	always_comb begin
		sub    = quo_s[NSTEP];
		sub[0] = rem_s[NSTEP][DIM_BITS-1:0];
	end

	assign out_vld  = vld_s[NSTEP];
	assign out_side = side_s[NSTEP];

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import cmic_pkg::*;

	// Drain for well past the pipeline depth of the block.
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 550;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t res;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = REG_DIM_COUNT;
	logic [DIM_BITS-1:0] cfg_wdata = '0;

	column_major_index_converter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Shadow of the array shape, updated together with every register write.
	logic [2:0] shape_count;
	logic [DIM_BITS-1:0] shape_size [4];

	req_t pending_reqs [$];
	res_t expected_results [$];
	int errors = 0;
	int cycles = 0;
	int gap_left = 0;

	// Predict one conversion result from the current shape.
	function automatic res_t convert_index(req_t r);
		res_t o;
		int unsigned nd;
		logic [63:0] stride [4];
		logic [63:0] total;
		logic [63:0] flat;
		logic [63:0] rem;
		logic [63:0] s;
		logic [DIM_BITS-1:0] subs [4];
		logic [DIM_BITS-1:0] q;
		bit oob;
		o = '0;
		nd = shape_count;
		if (nd < 1) nd = 1;
		if (nd > MAX_DIMS) nd = MAX_DIMS;
		total = 1;
		flat = 0;
		oob = 1'b0;
		subs[0] = r.sub_in0; subs[1] = r.sub_in1;
		subs[2] = r.sub_in2; subs[3] = r.sub_in3;
		for (int i = 0; i < 4; i++) stride[i] = 0;
		for (int i = 0; i < nd; i++) begin
			stride[i] = total;
			total = total * shape_size[i];
		end
		if (r.kind == 1'b0) begin
			for (int i = 0; i < nd; i++) begin
				s = 64'(subs[i]);
				if (s >= shape_size[i]) oob = 1'b1;
				flat = flat + s * stride[i];
			end
			if (!oob) o.flat_out = flat[FLAT_W-1:0];
		end else begin
			rem = 64'(r.flat_in);
			if (rem >= total) begin
				oob = 1'b1;
			end else begin
				for (int i = 3; i > 0; i--) begin
					q = '0;
					if (i < nd && stride[i] != 0) begin
						q = DIM_BITS'(rem / stride[i]);
						rem = rem - 64'(q) * stride[i];
					end
					case (i)
						1: o.sub_out1 = q;
						2: o.sub_out2 = q;
						default: o.sub_out3 = q;
					endcase
				end
				o.sub_out0 = rem[DIM_BITS-1:0];
			end
		end
		o.out_of_bounds = oob;
		return o;
	endfunction

	// Driver: one beat per pending item, with a random gap drawn per item.
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_results.push_back(convert_index(req));
			gap_left = $urandom_range(0, 4);
			if (gap_left != 0 || pending_reqs.size() == 0)
				start <= 1'b0;
			else
				req <= pending_reqs.pop_front();
		end else if (!start && pending_reqs.size() != 0 && arst_n) begin
			if (gap_left > 1) begin
				gap_left = gap_left - 1;
			end else begin
				req <= pending_reqs.pop_front();
				start <= 1'b1;
			end
		end
	end

	// Monitor: every done beat is checked against the oldest prediction.
	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				exp_res = expected_results.pop_front();
				if (res.flat_out !== exp_res.flat_out) begin
					$error("flat_out exp %0d got %0d", exp_res.flat_out, res.flat_out);
					errors++;
				end
				if (res.sub_out0 !== exp_res.sub_out0) begin
					$error("sub_out0 exp %0d got %0d", exp_res.sub_out0, res.sub_out0);
					errors++;
				end
				if (res.sub_out1 !== exp_res.sub_out1) begin
					$error("sub_out1 exp %0d got %0d", exp_res.sub_out1, res.sub_out1);
					errors++;
				end
				if (res.sub_out2 !== exp_res.sub_out2) begin
					$error("sub_out2 exp %0d got %0d", exp_res.sub_out2, res.sub_out2);
					errors++;
				end
				if (res.sub_out3 !== exp_res.sub_out3) begin
					$error("sub_out3 exp %0d got %0d", exp_res.sub_out3, res.sub_out3);
					errors++;
				end
				if (res.out_of_bounds !== exp_res.out_of_bounds) begin
					$error("out_of_bounds exp %0d got %0d", exp_res.out_of_bounds,
						res.out_of_bounds);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val[DIM_BITS-1:0];
		if (idx == REG_DIM_COUNT) shape_count = val[2:0];
		else if (idx <= REG_SIZE3) shape_size[2'(idx - REG_SIZE0)] = val[DIM_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_shape(input int unsigned nd, input int unsigned s0,
		input int unsigned s1, input int unsigned s2, input int unsigned s3);
		write_reg(REG_DIM_COUNT, nd);
		write_reg(REG_SIZE0, s0);
		write_reg(REG_SIZE1, s1);
		write_reg(REG_SIZE2, s2);
		write_reg(REG_SIZE3, s3);
	endtask

	// Wait until the pipeline has drained completely.
	task automatic settle();
		while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic req_t make_req(bit k, int unsigned a, int unsigned b,
		int unsigned c, int unsigned d, logic [FLAT_W-1:0] f);
		req_t r;
		r.kind = k;
		r.sub_in0 = DIM_BITS'(a); r.sub_in1 = DIM_BITS'(b);
		r.sub_in2 = DIM_BITS'(c); r.sub_in3 = DIM_BITS'(d);
		r.flat_in = f;
		return r;
	endfunction

	// Mostly in-range indices, sometimes one past the edge or anything.
	function automatic int unsigned pick_sub(logic [DIM_BITS-1:0] sz);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return $urandom_range(0, 1023);
		if (sel == 1) return sz;
		if (sz == 0) return 0;
		return $urandom_range(0, sz - 1);
	endfunction

	function automatic logic [FLAT_W-1:0] shape_total();
		logic [63:0] t;
		int unsigned nd;
		nd = shape_count;
		if (nd < 1) nd = 1;
		if (nd > MAX_DIMS) nd = MAX_DIMS;
		t = 1;
		for (int i = 0; i < nd; i++) t = t * shape_size[i];
		return t[FLAT_W-1:0];
	endfunction

	function automatic req_t random_req();
		logic [FLAT_W-1:0] t;
		logic [FLAT_W-1:0] f;
		int unsigned sel;
		t = shape_total();
		sel = $urandom_range(0, 9);
		f = FLAT_W'({$urandom, $urandom});
		if (sel < 7 && t != 0) f = f % t;
		else if (sel == 7) f = t;
		else if (sel == 8 && t != 0) f = t - 1;
		return make_req(1'($urandom_range(0, 1)), pick_sub(shape_size[0]),
			pick_sub(shape_size[1]), pick_sub(shape_size[2]),
			pick_sub(shape_size[3]), f);
	endfunction

	initial begin
		int unsigned nd;
		shape_count = 3'd2;
		for (int i = 0; i < 4; i++) shape_size[i] = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shape: 2 dims of extent 1, only zero is in range.
		pending_reqs.push_back(make_req(0, 0, 0, 1023, 1023, 0));
		pending_reqs.push_back(make_req(0, 1, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 1));
		settle();

		// Largest shape: extremes of every field.
		set_shape(4, 1023, 1023, 1023, 1023);
		pending_reqs.push_back(make_req(0, 1022, 1022, 1022, 1022, 0));
		pending_reqs.push_back(make_req(0, 1023, 0, 0, 0, '1));
		pending_reqs.push_back(make_req(0, 0, 0, 0, 1023, 0));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 40'd1095222947840));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 40'd1095222947839));
		pending_reqs.push_back(make_req(1, 1023, 1023, 1023, 1023, '1));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 40'd1046529));
		settle();

		// Count of zero acts as one dimension; unused indices ignored.
		set_shape(0, 7, 5, 3, 2);
		pending_reqs.push_back(make_req(0, 6, 1023, 1023, 1023, 0));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 6));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 7));
		settle();

		// Count above the maximum acts as four.
		write_reg(REG_DIM_COUNT, 7);
		pending_reqs.push_back(make_req(0, 6, 4, 2, 1, 0));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 209));
		settle();

		// Zero extent in use: everything out of bounds; then a stray index.
		write_reg(REG_SIZE2, 0);
		write_reg(3'd6, 5);
		pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 0));
		settle();

		// Random phases over a spread of shapes, mostly small ones.
		for (int ph = 0; ph < 11; ph++) begin
			nd = $urandom_range(0, 7);
			if (ph % 4 == 3)
				set_shape(nd, $urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023));
			else
				set_shape(nd, $urandom_range(1, 12), $urandom_range(1, 12),
					$urandom_range(1, 12), $urandom_range(1, 12));
			for (int k = 0; k < RANDOM_ITEMS / 11; k++)
				pending_reqs.push_back(random_req());
			settle();
		end

		if (errors == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			if (expected_results.size() != 0)
				$error("%0d results never arrived", expected_results.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> column_major_index_converter.f
+incdir+hw/rtl
hw/rtl/cmic_pkg.sv
hw/rtl/cmic_split.sv
hw/rtl/column_major_index_converter.sv
dv/tb.sv
